/* rtl/core/mlfs_pkg.sv */
`default_nettype none
package mlfs_pkg;

  localparam int unsigned MaxJobsDef = 16;
  localparam logic [7:0]  TimeoutRst = 8'd20;
  localparam logic [1:0]  TopLvl     = 2'd3;

  // event codes
  localparam logic [2:0] EV_LOADED  = 3'd0;
  localparam logic [2:0] EV_FULL    = 3'd1;
  localparam logic [2:0] EV_TIMEOUT = 3'd2;
  localparam logic [2:0] EV_FINISH  = 3'd3;
  localparam logic [2:0] EV_DEMOTED = 3'd4;
  localparam logic [2:0] EV_REALTM  = 3'd5;
  localparam logic [2:0] EV_IDLE    = 3'd6;
  localparam logic [2:0] EV_DONE    = 3'd7;

  typedef struct packed {
    logic [15:0] arrival;
    logic [1:0]  base_lvl;
    logic [1:0]  lvl;
    logic [7:0]  burst;
    logic [7:0]  left;
    logic        ended;
    logic        started;
  } entry_t;

  typedef struct packed {
    logic ld;         // load a job, or report full
    logic done_halt;  // already halted tick
    logic scan_clr;
    logic scan_eval;
    logic set_halt;   // halt now and report
    logic rr_init;
    logic rr_eval;
    logic rd_sel;
    logic run_exec;
    logic emit_idle;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic halted;
    logic now_zero;
    logic scan_last;
    logic any_active;
    logic best_found;
    logic rr_hit;
    logic rr_done;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/mlfs_ctrl.sv */
`default_nettype none
module mlfs_ctrl
  import mlfs_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  input  wire  cmd_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRD  = 3'd1;
  localparam logic [2:0] ST_SEV  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_QRD  = 3'd4;
  localparam logic [2:0] ST_QEV  = 3'd5;
  localparam logic [2:0] ST_RRD  = 3'd6;
  localparam logic [2:0] ST_REX  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && !cmd_i) begin
          cmd_o.ld = 1'b1;
        end else if (start && sts_i.halted) begin
          cmd_o.done_halt = 1'b1;
        end else if (start) begin
          cmd_o.scan_clr = 1'b1;
          state_d = sts_i.cnt_zero ? ST_DEC : ST_SRD;
        end
      end
      ST_SRD: state_d = ST_SEV;
      ST_SEV: begin
        cmd_o.scan_eval = 1'b1;
        state_d = sts_i.scan_last ? ST_DEC : ST_SRD;
      end
      ST_DEC: begin
        if (!sts_i.any_active && !sts_i.now_zero) begin
          cmd_o.set_halt = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.best_found) begin
          state_d = ST_RRD;
        end else if (sts_i.cnt_zero) begin
          cmd_o.emit_idle = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.rr_init = 1'b1;
          state_d = ST_QRD;
        end
      end
      ST_QRD: state_d = ST_QEV;
      ST_QEV: begin
        cmd_o.rr_eval = 1'b1;
        if (sts_i.rr_hit) begin
          state_d = ST_RRD;
        end else if (sts_i.rr_done) begin
          cmd_o.emit_idle = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_QRD;
        end
      end
      ST_RRD: begin
        cmd_o.rd_sel = 1'b1;
        state_d = ST_REX;
      end
      ST_REX: begin
        cmd_o.run_exec = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/mlfs_dpath.sv */
`default_nettype none
module mlfs_dpath
  import mlfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MaxJobsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  wire  [15:0] arrival_i,
  input  wire  [1:0]  priority_req_i,
  input  wire  [7:0]  burst_i,
  input  wire         cfg_valid_i,
  input  wire  [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  event_res_o,
  output logic [3:0]  job_id_o,
  output logic [1:0]  level_o,
  output logic [7:0]  remaining_o,
  output logic        first_run_o,
  output logic [15:0] tick_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic        last_o
);

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);

  entry_t tbl_q [MAX_JOBS];
  entry_t rd_q;
  entry_t wr_data;
  logic          we;
  logic [IW-1:0] wr_addr, rd_addr;

  logic [CW-1:0] count_q, count_d, n_q, n_d;
  logic [IW-1:0] idx_q, idx_d, sel_q, sel_d, rr_q, rr_d;
  logic [1:0]    best_q, best_d;
  logic          active_q, active_d, halted_q, halted_d;
  logic [15:0]   now_q, now_d;
  logic [7:0]    limit_q;

  logic          ov_d;
  logic [2:0]    ev_d;
  logic [IW-1:0] id_d;
  logic [1:0]    lvl_d;
  logic [7:0]    rem_d;
  logic          first_d, last_d;
  logic [15:0]   tick_d, tat_d, wt_d;

  logic [16:0] age, tat17, wt17;
  logic        arrived, timed, idx_last, rr_ok;
  logic [7:0]  left1;
  logic [IW-1:0] idx_nx;

  always_ff @(posedge clk_i) begin
    if (we) begin
      tbl_q[wr_addr] <= wr_data;
    end
    rd_q <= tbl_q[rd_addr];
  end

  assign rd_addr  = cmd_i.rd_sel ? sel_q : idx_q;
  assign age      = {1'b0, now_q} - {1'b0, rd_q.arrival};
  assign arrived  = !age[16];
  assign timed    = arrived && (age[15:0] > {8'd0, limit_q});
  assign idx_last = (CW'(idx_q) == CW'(count_q - CW'(1)));
  assign idx_nx   = idx_last ? '0 : IW'(idx_q + IW'(1));
  assign rr_ok    = !rd_q.ended && arrived && (rd_q.lvl == TopLvl);
  assign left1    = rd_q.left - 8'd1;
  assign tat17    = {1'b0, now_q} + 17'd1 - {1'b0, rd_q.arrival};
  assign wt17     = tat17 - {9'd0, rd_q.burst};

  always_comb begin
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.halted     = halted_q;
    sts_o.now_zero   = (now_q == 16'd0);
    sts_o.scan_last  = idx_last;
    sts_o.any_active = active_q;
    sts_o.best_found = (best_q != TopLvl);
    sts_o.rr_hit     = rr_ok;
    sts_o.rr_done    = (n_q == CW'(count_q - CW'(1)));
  end

  always_comb begin
    count_d = count_q; n_d = n_q; idx_d = idx_q; sel_d = sel_q; rr_d = rr_q;
    best_d = best_q; active_d = active_q; halted_d = halted_q; now_d = now_q;
    we = 1'b0; wr_addr = idx_q; wr_data = rd_q;
    ov_d = 1'b0; ev_d = EV_IDLE; id_d = '0; lvl_d = '0; rem_d = '0;
    first_d = 1'b0; last_d = 1'b1; tick_d = now_q; tat_d = '0; wt_d = '0;

    if (cmd_i.ld) begin
      ov_d = 1'b1;
      if (count_q >= CW'(MAX_JOBS)) begin
        ev_d = EV_FULL;
      end else begin
        we = 1'b1;
        wr_addr = count_q[IW-1:0];
        wr_data = '{arrival: arrival_i, base_lvl: priority_req_i, lvl: priority_req_i,
                    burst: burst_i, left: burst_i, ended: 1'b0, started: 1'b0};
        count_d = CW'(count_q + CW'(1));
        ev_d = EV_LOADED; id_d = count_q[IW-1:0]; lvl_d = priority_req_i; rem_d = burst_i;
      end
    end
    if (cmd_i.done_halt) begin
      ov_d = 1'b1; ev_d = EV_DONE;
    end
    if (cmd_i.scan_clr) begin
      idx_d = '0; best_d = TopLvl; active_d = 1'b0;
    end
    if (cmd_i.scan_eval) begin
      idx_d = idx_nx;
      if (!rd_q.ended) begin
        if (timed) begin
          we = 1'b1;
          wr_data.ended = 1'b1;
          ov_d = 1'b1; last_d = 1'b0; ev_d = EV_TIMEOUT; id_d = idx_q;
          lvl_d = rd_q.lvl; rem_d = rd_q.left; tat_d = age[15:0];
          wt_d = (age[15:0] >= {8'd0, rd_q.burst}) ? age[15:0] - {8'd0, rd_q.burst} : 16'd0;
        end else begin
          active_d = 1'b1;
          if (arrived && rd_q.lvl < best_q) begin
            best_d = rd_q.lvl; sel_d = idx_q;
          end
        end
      end
    end
    if (cmd_i.set_halt) begin
      halted_d = 1'b1; ov_d = 1'b1; ev_d = EV_DONE;
    end
    if (cmd_i.rr_init) begin
      idx_d = rr_q; n_d = '0;
    end
    if (cmd_i.rr_eval) begin
      if (rr_ok) begin
        sel_d = idx_q; rr_d = idx_nx;
      end else begin
        idx_d = idx_nx; n_d = CW'(n_q + CW'(1));
      end
    end
    if (cmd_i.emit_idle) begin
      ov_d = 1'b1; ev_d = EV_IDLE; now_d = now_q + 16'd1;
    end
    if (cmd_i.run_exec) begin
      now_d = now_q + 16'd1;
      we = 1'b1; wr_addr = sel_q;
      wr_data.started = 1'b1; wr_data.left = left1;
      ov_d = 1'b1; id_d = sel_q; first_d = !rd_q.started;
      if (left1 == 8'd0) begin
        wr_data.ended = 1'b1;
        ev_d = EV_FINISH; lvl_d = rd_q.lvl; tick_d = tat17[15:0] + rd_q.arrival;
        tat_d = tat17[16] ? 16'hFFFF : tat17[15:0];
        wt_d = (tat17 < {9'd0, rd_q.burst}) ? 16'd0 :
               (wt17[16] ? 16'hFFFF : wt17[15:0]);
      end else if (rd_q.base_lvl != 2'd0) begin
        wr_data.lvl = (rd_q.lvl == TopLvl) ? TopLvl : rd_q.lvl + 2'd1;
        ev_d = EV_DEMOTED; lvl_d = wr_data.lvl; rem_d = left1;
      end else begin
        ev_d = EV_REALTM; lvl_d = rd_q.lvl; rem_d = left1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; rr_q <= '0; now_q <= '0; halted_q <= 1'b0;
      limit_q <= TimeoutRst; result_valid_o <= 1'b0;
      best_q <= TopLvl; active_q <= 1'b0; n_q <= '0; idx_q <= '0; sel_q <= '0;
    end else begin
      count_q <= count_d; rr_q <= rr_d; now_q <= now_d; halted_q <= halted_d;
      best_q <= best_d; active_q <= active_d; n_q <= n_d; idx_q <= idx_d; sel_q <= sel_d;
      result_valid_o <= ov_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    event_res_o  <= ev_d;
    job_id_o     <= 4'(id_d);
    level_o      <= lvl_d;
    remaining_o  <= rem_d;
    first_run_o  <= first_d;
    tick_time_o  <= tick_d;
    turnaround_o <= tat_d;
    waiting_o    <= wt_d;
    last_o       <= last_d;
  end

  a_timeout_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && event_res_o == EV_TIMEOUT |-> !last_o) else $error("timeout last");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_JOBS)) else $error("count overflow");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt cleared");
  a_one_cmd_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_exec |-> !cmd_i.emit_idle && !cmd_i.scan_eval) else $error("cmd clash");

endmodule
`default_nettype wire

/* rtl/core/multilevel_feedback_scheduler.sv */
`default_nettype none
// Multilevel feedback queue scheduler with job timeout. Pulse start while busy
// is low: cmd_i=0 loads one job (one word back in the next cycle), cmd_i=1
// runs a tick. A tick walks the job table once, reading and then evaluating
// each job, for timeouts and the level 0..2 pick, then, if nothing was found
// there, walks it again in the same way for the round-robin level-3 pick; the
// table sits in a memory with a registered read port and a separate write
// port, and that read sets the pace. The final word of a tick is shown as
// busy goes low again. Each result word is shown for one cycle under
// result_valid_o with last_o on the final word of an item; the receiver
// cannot stall, so it must take every word as it comes. The timeout register
// may be written any time through the cfg channel (always ready).
module multilevel_feedback_scheduler
  import mlfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MaxJobsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         cmd_i,
  input  wire  [15:0] arrival_i,
  input  wire  [1:0]  priority_req_i,
  input  wire  [7:0]  burst_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  event_res_o,
  output logic [3:0]  job_id_o,
  output logic [1:0]  level_o,
  output logic [7:0]  remaining_o,
  output logic        first_run_o,
  output logic [15:0] tick_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic        last_o
);

  cmd_t cmd;
  sts_t sts;

  // config register takes writes every cycle
  assign cfg_ready_o = 1'b1;

  mlfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  mlfs_dpath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .arrival_i      (arrival_i),
    .priority_req_i (priority_req_i),
    .burst_i        (burst_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .event_res_o    (event_res_o),
    .job_id_o       (job_id_o),
    .level_o        (level_o),
    .remaining_o    (remaining_o),
    .first_run_o    (first_run_o),
    .tick_time_o    (tick_time_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

/* bench/tb_multilevel_feedback_scheduler.sv */
`default_nettype none
module tb_multilevel_feedback_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfs_pkg::*;

  // command codes on cmd_i
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int unsigned NumJobs    = MaxJobsDef;
  localparam int unsigned SettleCyc  = 100;     // outlasts the longest tick
  localparam int unsigned CycleLimit = 400000;

  // one result word as the block reports it
  typedef struct {
    logic [2:0]  ev;
    logic [3:0]  id;
    logic [1:0]  lvl;
    logic [7:0]  rem;
    logic        first;
    logic [15:0] tick;
    logic [15:0] tat;
    logic [15:0] wt;
    logic        last;
  } sched_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cmd_i;
  logic [15:0] arrival_i;
  logic [1:0]  priority_req_i;
  logic [7:0]  burst_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        result_valid_o;
  logic [2:0]  event_res_o;
  logic [3:0]  job_id_o;
  logic [1:0]  level_o;
  logic [7:0]  remaining_o;
  logic        first_run_o;
  logic [15:0] tick_time_o;
  logic [15:0] turnaround_o;
  logic [15:0] waiting_o;
  logic        last_o;

  multilevel_feedback_scheduler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .arrival_i      (arrival_i),
    .priority_req_i (priority_req_i),
    .burst_i        (burst_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .event_res_o    (event_res_o),
    .job_id_o       (job_id_o),
    .level_o        (level_o),
    .remaining_o    (remaining_o),
    .first_run_o    (first_run_o),
    .tick_time_o    (tick_time_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .last_o         (last_o)
  );

  // scheduler state mirrored in the bench
  logic [15:0] jt_arrival [NumJobs];
  logic [1:0]  jt_base    [NumJobs];
  logic [1:0]  jt_lvl     [NumJobs];
  logic [7:0]  jt_burst   [NumJobs];
  logic [7:0]  jt_left    [NumJobs];
  logic        jt_ended   [NumJobs];
  logic        jt_started [NumJobs];
  int unsigned jobs_loaded;
  int unsigned rr_ptr;
  logic [15:0] sched_now;
  logic        sched_halted;
  logic [7:0]  timeout_reg;

  sched_word_t pending_words[$];   // words owed by the block, oldest first
  int unsigned n_errors;
  int unsigned n_words;
  int unsigned n_items;
  int unsigned n_ticks;
  int unsigned n_timeouts;
  int unsigned n_finishes;
  int unsigned n_halts;
  int unsigned cycle_cnt;
  int unsigned burst_left;         // items left in the current sender burst
  bit          sender_idles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("timeout after %0d cycles, %0d words still owed", cycle_cnt,
                 pending_words.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [15:0] clamp16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hffff;
    return v[15:0];
  endfunction

  function automatic void owe_word(logic [2:0] ev, int unsigned id, logic [1:0] lvl,
                                   logic [7:0] rem, logic first, logic [15:0] tick,
                                   logic [15:0] tat, logic [15:0] wt);
    sched_word_t w;
    w.ev = ev; w.id = id[3:0]; w.lvl = lvl; w.rem = rem; w.first = first;
    w.tick = tick; w.tat = tat; w.wt = wt; w.last = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic bit can_run(int unsigned i, logic [1:0] lvl);
    return jt_arrival[i] <= sched_now && !jt_ended[i] && jt_lvl[i] == lvl;
  endfunction

  // pick the job to serve: levels 0..2 in table order, then level 3 round robin
  function automatic int select_job();
    int unsigned i;
    for (int l = 0; l < 3; l++)
      for (int unsigned j = 0; j < jobs_loaded; j++)
        if (can_run(j, l[1:0])) return j;
    if (jobs_loaded == 0) return -1;
    i = rr_ptr % jobs_loaded;
    for (int unsigned n = 0; n < jobs_loaded; n++) begin
      if (can_run(i, TopLvl)) begin
        rr_ptr = (i + 1) % jobs_loaded;
        return i;
      end
      i = (i + 1) % jobs_loaded;
    end
    return -1;
  endfunction

  // advance the mirrored scheduler by one accepted item and queue its words
  function automatic void schedule_item(logic cmd, logic [15:0] arr, logic [1:0] pri,
                                        logic [7:0] bst);
    int unsigned live;
    int          sel;
    longint      age;
    longint      tat;
    logic        first;
    live = 0;
    if (cmd == CMD_LOAD) begin
      if (jobs_loaded >= NumJobs) begin
        owe_word(EV_FULL, 0, 0, 0, 0, sched_now, 0, 0);
      end else begin
        jt_arrival[jobs_loaded] = arr;
        jt_base[jobs_loaded]    = pri;
        jt_lvl[jobs_loaded]     = pri;
        jt_burst[jobs_loaded]   = bst;
        jt_left[jobs_loaded]    = bst;
        jt_ended[jobs_loaded]   = 1'b0;
        jt_started[jobs_loaded] = 1'b0;
        owe_word(EV_LOADED, jobs_loaded, pri, bst, 0, sched_now, 0, 0);
        jobs_loaded++;
      end
      pending_words[pending_words.size()-1].last = 1'b1;
      return;
    end
    n_ticks++;
    if (sched_halted) begin
      owe_word(EV_DONE, 0, 0, 0, 0, sched_now, 0, 0);
      pending_words[pending_words.size()-1].last = 1'b1;
      return;
    end
    // timeout sweep over live jobs
    for (int unsigned i = 0; i < jobs_loaded; i++) begin
      if (jt_ended[i]) continue;
      age = longint'(sched_now) - longint'(jt_arrival[i]);
      if (age > longint'(timeout_reg)) begin
        jt_ended[i] = 1'b1;
        n_timeouts++;
        owe_word(EV_TIMEOUT, i, jt_lvl[i], jt_left[i], 0, sched_now, clamp16(age),
                 clamp16(age - longint'(jt_burst[i])));
      end else begin
        live++;
      end
    end
    if (live == 0 && sched_now != 0) begin
      sched_halted = 1'b1;
      n_halts++;
      owe_word(EV_DONE, 0, 0, 0, 0, sched_now, 0, 0);
      pending_words[pending_words.size()-1].last = 1'b1;
      return;
    end
    sel = select_job();
    if (sel < 0) begin
      owe_word(EV_IDLE, 0, 0, 0, 0, sched_now, 0, 0);
    end else begin
      first = !jt_started[sel];
      jt_started[sel] = 1'b1;
      jt_left[sel] = jt_left[sel] - 8'd1;
      if (jt_left[sel] == 0) begin
        // finishing job ends one tick later; turnaround uses the unwrapped time
        tat = longint'(sched_now) + 1 - longint'(jt_arrival[sel]);
        if (tat < 0) tat = 0;
        jt_ended[sel] = 1'b1;
        n_finishes++;
        owe_word(EV_FINISH, sel, jt_lvl[sel], 0, first, sched_now + 16'd1, clamp16(tat),
                 clamp16(tat - longint'(jt_burst[sel])));
      end else if (jt_base[sel] != 0) begin
        if (jt_lvl[sel] < TopLvl) jt_lvl[sel] = jt_lvl[sel] + 2'd1;
        owe_word(EV_DEMOTED, sel, jt_lvl[sel], jt_left[sel], first, sched_now, 0, 0);
      end else begin
        owe_word(EV_REALTM, sel, jt_lvl[sel], jt_left[sel], first, sched_now, 0, 0);
      end
    end
    sched_now = sched_now + 16'd1;
    pending_words[pending_words.size()-1].last = 1'b1;
  endfunction

  // result checker: every strobed word against the oldest owed word
  always @(posedge clk_i) begin
    sched_word_t w;
    if (rst_ni && result_valid_o) begin
      n_words++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: event %0d job %0d", event_res_o, job_id_o);
        n_errors++;
      end else begin
        w = pending_words.pop_front();
        if (event_res_o !== w.ev) begin
          $error("event_res: expected %0d, got %0d", w.ev, event_res_o); n_errors++;
        end
        if (job_id_o !== w.id) begin
          $error("job_id: expected %0d, got %0d", w.id, job_id_o); n_errors++;
        end
        if (level_o !== w.lvl) begin
          $error("level: expected %0d, got %0d", w.lvl, level_o); n_errors++;
        end
        if (remaining_o !== w.rem) begin
          $error("remaining: expected %0d, got %0d", w.rem, remaining_o); n_errors++;
        end
        if (first_run_o !== w.first) begin
          $error("first_run: expected %0d, got %0d", w.first, first_run_o); n_errors++;
        end
        if (tick_time_o !== w.tick) begin
          $error("tick_time: expected %0d, got %0d", w.tick, tick_time_o); n_errors++;
        end
        if (turnaround_o !== w.tat) begin
          $error("turnaround: expected %0d, got %0d", w.tat, turnaround_o); n_errors++;
        end
        if (waiting_o !== w.wt) begin
          $error("waiting: expected %0d, got %0d", w.wt, waiting_o); n_errors++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last_o); n_errors++;
        end
      end
    end
  end

  // hand one item to the block; start stays high so a back-to-back item follows
  task automatic send_item(logic cmd, logic [15:0] arr, logic [1:0] pri, logic [7:0] bst);
    bit taken;
    @(negedge clk_i);
    start          <= 1'b1;
    cmd_i          <= cmd;
    arrival_i      <= arr;
    priority_req_i <= pri;
    burst_i        <= bst;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1'b1;
        schedule_item(cmd, arr, pri, bst);
        n_items++;
      end
    end
    // sender bursts: when the sender idles, a random gap closes each burst
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (sender_idles) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 16'($urandom), 2'($urandom), 8'($urandom));
  endtask

  // drain, let a tick with no word in flight settle, then write the timeout
  task automatic write_timeout(logic [7:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // empty table at time zero is idle, not done
  task automatic test_empty_tick();
    send_tick();
  endtask

  // fill all slots with the corner cases, then overflow
  task automatic test_fill_table();
    send_item(CMD_LOAD, 16'd1,  2'd0, 8'd3);     // real-time, never demoted
    send_item(CMD_LOAD, 16'd2,  2'd1, 8'd5);
    send_item(CMD_LOAD, 16'd3,  2'd2, 8'd0);     // zero burst wraps on first run
    send_item(CMD_LOAD, 16'd0,  2'd3, 8'd255);   // longest burst, round robin
    send_item(CMD_LOAD, 16'd1,  2'd3, 8'd4);
    send_item(CMD_LOAD, 16'd50, 2'd3, 8'd2);     // arrives later
    send_item(CMD_LOAD, 16'd0,  2'd1, 8'd1);     // finishes on first run
    for (int k = 7; k < NumJobs; k++)
      send_item(CMD_LOAD, 16'($urandom_range(0, 300)), 2'($urandom),
                8'($urandom_range(1, 12)));
    send_item(CMD_LOAD, 16'hffff, 2'd3, 8'd255); // table full
    send_item(CMD_LOAD, 16'h0000, 2'd0, 8'd0);
  endtask

  task automatic test_directed_ticks();
    repeat (5) send_tick();
    write_timeout(8'd255);
    repeat (2) send_tick();
  endtask

  // mostly ticks with some rejected loads, timeout changed between phases
  task automatic test_random_traffic();
    logic [7:0] limits [5];
    limits[0] = 8'($urandom_range(10, 60));
    limits[1] = 8'd255;
    limits[2] = 8'($urandom);
    limits[3] = 8'd5;
    limits[4] = 8'd0;                            // drives everything out: halt
    for (int ph = 0; ph < 5; ph++) begin
      write_timeout(limits[ph]);
      sender_idles = (ph != 1);                  // one phase runs back to back
      repeat (68) begin
        if ($urandom_range(0, 99) < 85) send_tick();
        else send_item(CMD_LOAD, 16'($urandom), 2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    n_errors = 0; n_words = 0; n_items = 0; n_ticks = 0;
    n_timeouts = 0; n_finishes = 0; n_halts = 0;
    jobs_loaded = 0; rr_ptr = 0; sched_now = '0; sched_halted = 1'b0;
    timeout_reg = TimeoutRst;
    burst_left = 1; sender_idles = 1'b1;
    rst_ni = 1'b0; start = 1'b0; cmd_i = CMD_LOAD; arrival_i = '0;
    priority_req_i = '0; burst_i = '0; cfg_valid_i = 1'b0; cfg_data_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_tick();
    test_fill_table();
    test_directed_ticks();
    test_random_traffic();

    // wait out the tail
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);

    $display("covered %0d items (%0d ticks) and %0d words", n_items, n_ticks, n_words);
    $display("timeouts %0d, finishes %0d, halts %0d", n_timeouts, n_finishes, n_halts);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
